>>> rtl/lfps_pkg.sv
// ----------------------------------------------------------------------------
// lfps_pkg
// Shared types and constants for the line-follow PID steering block.
// ----------------------------------------------------------------------------
package lfps_pkg;

    // Field and arithmetic widths
    localparam int SAMPLE_BITS   = 10;
    localparam int SPEED_LIMIT   = 150;
    localparam int SUM_BITS      = 16;
    localparam int SPEED_BITS    = 8;
    localparam int GAIN_BITS     = 12;
    localparam int ERR_BITS      = 2;
    localparam int DIFF_BITS     = ERR_BITS + 1;
    localparam int OFFSET_BITS   = 8;
    localparam int CFG_IDX_BITS  = 3;
    localparam int CFG_DATA_BITS = 12;

    // PID output limit (+-2.0 in Q.8) and scaling
    localparam int PID_LIMIT     = 512;
    localparam int PID_BITS      = 11;
    localparam int SCALE_FACTOR  = 100;
    localparam int SCALE_SHIFT   = 8;

    // Shared multiplier operands: unsigned gains carried as signed
    localparam int OPA_BITS      = GAIN_BITS + 1;
    localparam int OPB_BITS      = (SUM_BITS + 1 > PID_BITS) ? SUM_BITS + 1 : PID_BITS;
    localparam int PROD_BITS     = OPA_BITS + OPB_BITS;
    localparam int ACC_BITS      = PROD_BITS + 2;
    localparam int SPD_CALC_BITS = SPEED_BITS + 2;

    // Register reset values
    localparam logic [SAMPLE_BITS-1:0] THRESHOLD_RST = SAMPLE_BITS'(500);
    localparam logic [SPEED_BITS-1:0]  BASE_RST      = SPEED_BITS'(50);
    localparam logic [GAIN_BITS-1:0]   GAIN_P_RST    = GAIN_BITS'(128);
    localparam logic [GAIN_BITS-1:0]   GAIN_I_RST    = GAIN_BITS'(26);
    localparam logic [GAIN_BITS-1:0]   GAIN_D_RST    = GAIN_BITS'(26);

    // Configuration register indexes
    localparam logic [CFG_IDX_BITS-1:0] CFG_LINE_THRESHOLD = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_BASE_SPEED     = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_GAIN_P         = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] CFG_GAIN_I         = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] CFG_GAIN_D         = 3'd4;

    // Sequencer steps
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL_P,
        ST_MUL_I,
        ST_MUL_D,
        ST_CLAMP,
        ST_SCALE,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic en;     // update accumulator
        logic first;  // load product instead of adding
    } t_mac_ctrl;

    typedef struct packed {
        logic      in_ready;
        logic      clamp_en;
        logic      out_load;
        t_mac_ctrl mac;
    } t_seq_ctrl;

endpackage

>>> rtl/lfps_in_if.sv
// ----------------------------------------------------------------------------
// lfps_in_if
// Sensor sample channel: valid/ready with three reflectance samples.
// ----------------------------------------------------------------------------
interface lfps_in_if;
    logic                             valid;
    logic                             ready;
    logic [lfps_pkg::SAMPLE_BITS-1:0] left_sample;
    logic [lfps_pkg::SAMPLE_BITS-1:0] middle_sample;
    logic [lfps_pkg::SAMPLE_BITS-1:0] right_sample;

    modport source (output valid, left_sample, middle_sample, right_sample, input ready);
    modport sink   (input valid, left_sample, middle_sample, right_sample, output ready);
endinterface

>>> rtl/lfps_out_if.sv
// ----------------------------------------------------------------------------
// lfps_out_if
// Steering result channel: valid/ready with motor speeds and status.
// ----------------------------------------------------------------------------
interface lfps_out_if;
    logic                                   valid;
    logic                                   ready;
    logic [lfps_pkg::SPEED_BITS-1:0]        left_speed;
    logic [lfps_pkg::SPEED_BITS-1:0]        right_speed;
    logic signed [lfps_pkg::ERR_BITS-1:0]   line_error;
    logic signed [lfps_pkg::OFFSET_BITS-1:0] steer_offset;
    logic                                   line_lost;
    logic                                   search_turn_left;

    modport source (output valid, left_speed, right_speed, line_error, steer_offset,
                    line_lost, search_turn_left, input ready);
    modport sink   (input valid, left_speed, right_speed, line_error, steer_offset,
                    line_lost, search_turn_left, output ready);
endinterface

>>> rtl/lfps_mac.sv
// ----------------------------------------------------------------------------
// lfps_mac
// Shared signed multiply-accumulate unit, one product per cycle.
// ----------------------------------------------------------------------------
module lfps_mac (
    input  logic                                 i_clk,
    input  lfps_pkg::t_mac_ctrl                  i_ctrl,
    input  logic signed [lfps_pkg::OPA_BITS-1:0] i_op_a,
    input  logic signed [lfps_pkg::OPB_BITS-1:0] i_op_b,
    output logic signed [lfps_pkg::ACC_BITS-1:0] o_acc
);

    logic signed [lfps_pkg::PROD_BITS-1:0] prod;
    logic signed [lfps_pkg::ACC_BITS-1:0]  prod_ext;
    logic signed [lfps_pkg::ACC_BITS-1:0]  r_acc;
    logic signed [lfps_pkg::ACC_BITS-1:0]  n_acc;

    assign prod     = i_op_a * i_op_b;
    assign prod_ext = lfps_pkg::ACC_BITS'(prod);

    always_comb begin
        n_acc = r_acc;
        if (i_ctrl.en) begin
            if (i_ctrl.first) begin
                n_acc = prod_ext;
            end else begin
                n_acc = r_acc + prod_ext;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_acc <= n_acc;
    end

    assign o_acc = r_acc;

endmodule

>>> rtl/lfps_seq.sv
// ----------------------------------------------------------------------------
// lfps_seq
// Step sequencer driving the shared multiplier through one PID evaluation.
// ----------------------------------------------------------------------------
module lfps_seq (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  logic                i_out_free,
    output lfps_pkg::t_state    o_state,
    output lfps_pkg::t_seq_ctrl o_ctrl
);

    lfps_pkg::t_state r_state;
    lfps_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= lfps_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            lfps_pkg::ST_IDLE:  if (i_in_valid) n_state = lfps_pkg::ST_MUL_P;
            lfps_pkg::ST_MUL_P: n_state = lfps_pkg::ST_MUL_I;
            lfps_pkg::ST_MUL_I: n_state = lfps_pkg::ST_MUL_D;
            lfps_pkg::ST_MUL_D: n_state = lfps_pkg::ST_CLAMP;
            lfps_pkg::ST_CLAMP: n_state = lfps_pkg::ST_SCALE;
            lfps_pkg::ST_SCALE: n_state = lfps_pkg::ST_DONE;
            lfps_pkg::ST_DONE:  if (i_out_free) n_state = lfps_pkg::ST_IDLE;
            default:            n_state = lfps_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        o_ctrl = '0;
        unique case (r_state)
            lfps_pkg::ST_IDLE:  o_ctrl.in_ready = 1'b1;
            lfps_pkg::ST_MUL_P: begin
                o_ctrl.mac.en    = 1'b1;
                o_ctrl.mac.first = 1'b1;
            end
            lfps_pkg::ST_MUL_I: o_ctrl.mac.en = 1'b1;
            lfps_pkg::ST_MUL_D: o_ctrl.mac.en = 1'b1;
            lfps_pkg::ST_CLAMP: o_ctrl.clamp_en = 1'b1;
            lfps_pkg::ST_SCALE: begin
                o_ctrl.mac.en    = 1'b1;
                o_ctrl.mac.first = 1'b1;
            end
            lfps_pkg::ST_DONE:  o_ctrl.out_load = i_out_free;
            default:            o_ctrl = '0;
        endcase
    end

    assign o_state = r_state;

endmodule

>>> rtl/line_follow_pid_steering.sv
// ----------------------------------------------------------------------------
// line_follow_pid_steering
// Three-sensor line follower with fixed-point PID steering.
// ----------------------------------------------------------------------------
// Takes one sensor triple at a time and returns one steering result for it.
// An item goes from transfer in to result loaded through the transfer
// cycle, then six steps of the sequencer, four of which go through the one
// shared 13x17 signed multiplier (P, I and D products, then the scaling by
// 100). The result sits in an output register; the block stays busy only if
// that register is still held when the next result is ready. Configuration
// writes are registered and must only be made while the block is idle.
// ----------------------------------------------------------------------------
module line_follow_pid_steering (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_we,
    input  logic [lfps_pkg::CFG_IDX_BITS-1:0]    i_cfg_idx,
    input  logic [lfps_pkg::CFG_DATA_BITS-1:0]   i_cfg_data,
    lfps_in_if.sink                              i_in,
    lfps_out_if.source                           o_out
);

    // ---------------------------------------------------------------- config
    logic [lfps_pkg::SAMPLE_BITS-1:0] r_line_threshold;
    logic [lfps_pkg::SPEED_BITS-1:0]  r_base_speed;
    logic [lfps_pkg::GAIN_BITS-1:0]   r_gain_p;
    logic [lfps_pkg::GAIN_BITS-1:0]   r_gain_i;
    logic [lfps_pkg::GAIN_BITS-1:0]   r_gain_d;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_line_threshold <= lfps_pkg::THRESHOLD_RST;
            r_base_speed     <= lfps_pkg::BASE_RST;
            r_gain_p         <= lfps_pkg::GAIN_P_RST;
            r_gain_i         <= lfps_pkg::GAIN_I_RST;
            r_gain_d         <= lfps_pkg::GAIN_D_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                lfps_pkg::CFG_LINE_THRESHOLD:
                    r_line_threshold <= i_cfg_data[lfps_pkg::SAMPLE_BITS-1:0];
                lfps_pkg::CFG_BASE_SPEED:
                    r_base_speed <= i_cfg_data[lfps_pkg::SPEED_BITS-1:0];
                lfps_pkg::CFG_GAIN_P: r_gain_p <= i_cfg_data[lfps_pkg::GAIN_BITS-1:0];
                lfps_pkg::CFG_GAIN_I: r_gain_i <= i_cfg_data[lfps_pkg::GAIN_BITS-1:0];
                lfps_pkg::CFG_GAIN_D: r_gain_d <= i_cfg_data[lfps_pkg::GAIN_BITS-1:0];
                default: ;  // unmapped index, write dropped
            endcase
        end
    end

    // ------------------------------------------------------------- sequencer
    lfps_pkg::t_state    st;
    lfps_pkg::t_seq_ctrl seq_ctrl;
    logic                out_free;
    logic                accept;
    logic                r_out_valid;

    assign out_free = !r_out_valid || o_out.ready;
    assign accept   = i_in.valid && seq_ctrl.in_ready;
    assign i_in.ready = seq_ctrl.in_ready;

    lfps_seq u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .i_out_free (out_free),
        .o_state    (st),
        .o_ctrl     (seq_ctrl)
    );

    // --------------------------------------------------------------- sensing
    // Error is resolved on the transfer cycle; state updates land at once.
    logic                                   seen_l;
    logic                                   seen_m;
    logic                                   seen_r;
    logic                                   lost;
    logic signed [lfps_pkg::ERR_BITS-1:0]   err_seen;
    logic signed [lfps_pkg::ERR_BITS-1:0]   err_cur;
    logic signed [lfps_pkg::ERR_BITS-1:0]   n_direction;
    logic signed [lfps_pkg::SUM_BITS:0]     sum_wide;
    logic signed [lfps_pkg::SUM_BITS-1:0]   n_error_sum;
    logic signed [lfps_pkg::DIFF_BITS-1:0]  diff;

    logic signed [lfps_pkg::ERR_BITS-1:0]   r_direction;
    logic signed [lfps_pkg::SUM_BITS-1:0]   r_error_sum;
    logic signed [lfps_pkg::ERR_BITS-1:0]   r_prev_error;
    logic signed [lfps_pkg::ERR_BITS-1:0]   r_err;
    logic signed [lfps_pkg::DIFF_BITS-1:0]  r_diff;
    logic                                   r_lost;
    logic                                   r_turn_left;

    localparam logic signed [lfps_pkg::SUM_BITS:0] SUM_MAX =
        (lfps_pkg::SUM_BITS+1)'((64'sd1 <<< (lfps_pkg::SUM_BITS - 1)) - 64'sd1);
    localparam logic signed [lfps_pkg::SUM_BITS:0] SUM_MIN =
        (lfps_pkg::SUM_BITS+1)'(-SUM_MAX - 1);

    assign seen_l = i_in.left_sample   > r_line_threshold;
    assign seen_m = i_in.middle_sample > r_line_threshold;
    assign seen_r = i_in.right_sample  > r_line_threshold;
    assign lost   = !(seen_l || seen_m || seen_r);

    always_comb begin
        err_seen = '0;
        if (seen_r && !seen_l) begin
            err_seen = 2'sd1;
        end else if (seen_l && !seen_r) begin
            err_seen = -2'sd1;
        end
    end

    assign err_cur = lost ? r_direction : err_seen;

    // Direction memory: left and right both seen without middle keeps it
    always_comb begin
        n_direction = r_direction;
        if (!lost) begin
            if (err_seen != '0) begin
                n_direction = err_seen;
            end else if (seen_m) begin
                n_direction = '0;
            end
        end
    end

    // Saturating integral
    assign sum_wide = (lfps_pkg::SUM_BITS+1)'(r_error_sum)
                    + (lfps_pkg::SUM_BITS+1)'(err_cur);
    always_comb begin
        if (sum_wide > SUM_MAX) begin
            n_error_sum = lfps_pkg::SUM_BITS'(SUM_MAX);
        end else if (sum_wide < SUM_MIN) begin
            n_error_sum = lfps_pkg::SUM_BITS'(SUM_MIN);
        end else begin
            n_error_sum = sum_wide[lfps_pkg::SUM_BITS-1:0];
        end
    end

    assign diff = lfps_pkg::DIFF_BITS'(err_cur) - lfps_pkg::DIFF_BITS'(r_prev_error);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_direction  <= '0;
            r_error_sum  <= '0;
            r_prev_error <= '0;
        end else if (accept) begin
            r_direction  <= n_direction;
            r_error_sum  <= n_error_sum;
            r_prev_error <= err_cur;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_err       <= err_cur;
            r_diff      <= diff;
            r_lost      <= lost;
            r_turn_left <= lost && (r_direction == 2'sd1);
        end
    end

    // ------------------------------------------------------ shared multiplier
    // Operand select per step: P, I, D products accumulate; SCALE reloads.
    logic signed [lfps_pkg::OPA_BITS-1:0] op_a;
    logic signed [lfps_pkg::OPB_BITS-1:0] op_b;
    logic signed [lfps_pkg::ACC_BITS-1:0] mac_acc;
    logic signed [lfps_pkg::PID_BITS-1:0] r_pid_clamped;

    always_comb begin
        op_a = '0;
        op_b = '0;
        unique case (st)
            lfps_pkg::ST_MUL_P: begin
                op_a = $signed({1'b0, r_gain_p});
                op_b = lfps_pkg::OPB_BITS'(r_err);
            end
            lfps_pkg::ST_MUL_I: begin
                op_a = $signed({1'b0, r_gain_i});
                op_b = lfps_pkg::OPB_BITS'(r_error_sum);
            end
            lfps_pkg::ST_MUL_D: begin
                op_a = $signed({1'b0, r_gain_d});
                op_b = lfps_pkg::OPB_BITS'(r_diff);
            end
            lfps_pkg::ST_SCALE: begin
                op_a = lfps_pkg::OPA_BITS'(lfps_pkg::SCALE_FACTOR);
                op_b = lfps_pkg::OPB_BITS'(r_pid_clamped);
            end
            default: begin
                op_a = '0;
                op_b = '0;
            end
        endcase
    end

    lfps_mac u_mac (
        .i_clk  (i_clk),
        .i_ctrl (seq_ctrl.mac),
        .i_op_a (op_a),
        .i_op_b (op_b),
        .o_acc  (mac_acc)
    );

    // Clamp PID sum to +-2.0
    always_ff @(posedge i_clk) begin
        if (seq_ctrl.clamp_en) begin
            if (mac_acc > lfps_pkg::PID_LIMIT) begin
                r_pid_clamped <= lfps_pkg::PID_BITS'(lfps_pkg::PID_LIMIT);
            end else if (mac_acc < -lfps_pkg::PID_LIMIT) begin
                r_pid_clamped <= lfps_pkg::PID_BITS'(-lfps_pkg::PID_LIMIT);
            end else begin
                r_pid_clamped <= mac_acc[lfps_pkg::PID_BITS-1:0];
            end
        end
    end

    // ------------------------------------------------------- offset, speeds
    // /256 toward zero then floor /2 folds into one biased floor shift by 9.
    localparam int OFS_SHIFT = lfps_pkg::SCALE_SHIFT + 1;

    logic signed [lfps_pkg::ACC_BITS-1:0]      biased;
    logic signed [lfps_pkg::ACC_BITS-1:0]      ofs_wide;
    logic signed [lfps_pkg::OFFSET_BITS-1:0]   offset;
    logic signed [lfps_pkg::SPD_CALC_BITS-1:0] base_ext;
    logic signed [lfps_pkg::SPD_CALC_BITS-1:0] ofs_ext;
    logic signed [lfps_pkg::SPD_CALC_BITS-1:0] left_raw;
    logic signed [lfps_pkg::SPD_CALC_BITS-1:0] right_raw;
    logic [lfps_pkg::SPEED_BITS-1:0]           left_spd;
    logic [lfps_pkg::SPEED_BITS-1:0]           right_spd;

    assign biased   = mac_acc + (mac_acc[lfps_pkg::ACC_BITS-1]
                      ? lfps_pkg::ACC_BITS'((1 << lfps_pkg::SCALE_SHIFT) - 1)
                      : lfps_pkg::ACC_BITS'(0));
    assign ofs_wide = biased >>> OFS_SHIFT;
    assign offset   = ofs_wide[lfps_pkg::OFFSET_BITS-1:0];

    assign base_ext  = $signed({2'b00, r_base_speed});
    assign ofs_ext   = lfps_pkg::SPD_CALC_BITS'(offset);
    assign left_raw  = base_ext - ofs_ext;
    assign right_raw = base_ext + ofs_ext;

    always_comb begin
        if (left_raw < 0) begin
            left_spd = '0;
        end else if (left_raw > lfps_pkg::SPEED_LIMIT) begin
            left_spd = lfps_pkg::SPEED_BITS'(lfps_pkg::SPEED_LIMIT);
        end else begin
            left_spd = left_raw[lfps_pkg::SPEED_BITS-1:0];
        end
        if (right_raw < 0) begin
            right_spd = '0;
        end else if (right_raw > lfps_pkg::SPEED_LIMIT) begin
            right_spd = lfps_pkg::SPEED_BITS'(lfps_pkg::SPEED_LIMIT);
        end else begin
            right_spd = right_raw[lfps_pkg::SPEED_BITS-1:0];
        end
    end

    // -------------------------------------------------------- output register
    logic [lfps_pkg::SPEED_BITS-1:0]         r_left_speed;
    logic [lfps_pkg::SPEED_BITS-1:0]         r_right_speed;
    logic signed [lfps_pkg::ERR_BITS-1:0]    r_line_error;
    logic signed [lfps_pkg::OFFSET_BITS-1:0] r_steer_offset;
    logic                                    r_line_lost;
    logic                                    r_search_left;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (seq_ctrl.out_load) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (seq_ctrl.out_load) begin
            r_left_speed   <= left_spd;
            r_right_speed  <= right_spd;
            r_line_error   <= r_err;
            r_steer_offset <= offset;
            r_line_lost    <= r_lost;
            r_search_left  <= r_turn_left;
        end
    end

    assign o_out.valid            = r_out_valid;
    assign o_out.left_speed       = r_left_speed;
    assign o_out.right_speed      = r_right_speed;
    assign o_out.line_error       = r_line_error;
    assign o_out.steer_offset     = r_steer_offset;
    assign o_out.line_lost        = r_line_lost;
    assign o_out.search_turn_left = r_search_left;

`ifndef SYNTHESIS
    a_accept_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> (st == lfps_pkg::ST_MUL_P))
        else $error("transfer in did not start the P step");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        seq_ctrl.out_load |-> (!r_out_valid || o_out.ready))
        else $error("result loaded over a pending one");

    a_prev_err_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_prev_error != -2'sd2)
        else $error("stored error outside -1..1");

    a_offset_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        seq_ctrl.out_load |-> (offset <= 8'sd100 && offset >= -8'sd100))
        else $error("steering offset beyond +-100");
`endif

endmodule
